### rtl/core/sik_pkg.sv
// Shared types, constants and arithmetic helpers for the SCARA inverse kinematics core.
`timescale 1ns / 1ps
package sik_pkg;

	// Fixed formats
	localparam int WORD_BITS     = 32;
	localparam int LINK_W        = WORD_BITS - 1;
	localparam int FRACTION_BITS = 16;
	localparam int CORDIC_STAGES = 18;
	localparam int NORM_BITS     = 30;
	localparam int ANGLE_BITS    = 60;
	localparam int ROUND_SHIFT   = ANGLE_BITS - FRACTION_BITS;
	localparam int WIDE          = 2 * WORD_BITS;
	localparam int LEN_W         = 7;
	localparam int RAD_W         = 2 * NORM_BITS;
	localparam int CW            = NORM_BITS + 4;
	localparam int SERIES_TERMS  = 32;

	// Stream words
	localparam int IN_W       = 3 * WORD_BITS;
	localparam int SHOULDER_W = 20;
	localparam int ELBOW_W    = 18;
	localparam int ELBOW_EXT_W = 21;
	localparam int OUT_W      = 72;

	// Register map
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_LINK  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_LINK = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_Z_LOWEST    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_Z_HIGHEST   = 2'd3;

	typedef struct packed {
		logic [LINK_W-1:0]           a;
		logic [LINK_W-1:0]           b;
		logic signed [WORD_BITS-1:0] z_lo;
		logic signed [WORD_BITS-1:0] z_hi;
	} sik_cfg_t;

	localparam sik_cfg_t CFG_RESET = '{
		a: 31'd131072,
		b: 31'd65536,
		z_lo: -32'sd196608,
		z_hi: -32'sd19661
	};

	// Target terms that ride along with the arithmetic
	typedef struct packed {
		logic                        nx;
		logic                        ny;
		logic [WORD_BITS-1:0]        ux;
		logic [WORD_BITS-1:0]        uy;
		logic signed [WORD_BITS-1:0] lift;
	} sik_xy_t;

	typedef struct packed {
		sik_xy_t              xy;
		logic                 reach;
		logic                 kneg;
		logic [NORM_BITS-1:0] kn;
		logic                 dneg;
		logic [WIDE-1:0]      dm;
	} sik_side_t;

	// Elaboration-time angle constants (Q60)
	localparam logic [WIDE-1:0] ONE_Q60    = 64'd1 << ANGLE_BITS;
	localparam logic [WIDE-1:0] Five       = 64'd5;
	localparam logic [WIDE-1:0] TwentyFive = 64'd25;
	localparam logic [WIDE-1:0] Big        = 64'd239;
	localparam logic [WIDE-1:0] BigSq      = 64'd57121;

	// atan(1/5) or atan(1/239) by its power series
	function automatic logic signed [WIDE-1:0] atan_recip(input logic use_big);
		logic [WIDE-1:0] term;
		logic [WIDE-1:0] part;
		logic signed [WIDE-1:0] sum;
		term = use_big ? (ONE_Q60 / Big) : (ONE_Q60 / Five);
		sum = '0;
		for (int k = 0; k < SERIES_TERMS; k++) begin
			part = term / 64'(2 * k + 1);
			if ((k & 1) != 0) sum = sum - signed'(part);
			else sum = sum + signed'(part);
			term = use_big ? (term / BigSq) : (term / TwentyFive);
		end
		return sum;
	endfunction

	localparam logic signed [WIDE-1:0] QUARTER_PI_Q60 = 4 * atan_recip(1'b0) - atan_recip(1'b1);
	localparam logic signed [WIDE-1:0] PI_Q60 = 4 * QUARTER_PI_Q60;

	// atan(2^-i), Q60
	function automatic logic signed [WIDE-1:0] atan_pow2(input int i);
		logic [WIDE-1:0] term;
		logic [WIDE-1:0] part;
		logic signed [WIDE-1:0] sum;
		term = ONE_Q60 >> i;
		sum = '0;
		for (int k = 0; k < SERIES_TERMS; k++) begin
			part = term / 64'(2 * k + 1);
			if ((k & 1) != 0) sum = sum - signed'(part);
			else sum = sum + signed'(part);
			term = term >> (2 * i);
		end
		return (i == 0) ? QUARTER_PI_Q60 : sum;
	endfunction

	// Q60 to Q16, round half away from zero
	function automatic logic signed [WIDE-1:0] to_fixed(input logic signed [WIDE-1:0] q);
		logic [WIDE-1:0] mag;
		logic [WIDE-1:0] rnd;
		mag = q[WIDE-1] ? (~q + 64'd1) : q;
		rnd = (mag + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
		return q[WIDE-1] ? -signed'(rnd) : signed'(rnd);
	endfunction

	localparam logic signed [WIDE-1:0] PI_FIXED = to_fixed(PI_Q60);

	// Shift right, rounding toward zero
	function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
		input int s);
		logic [CW-1:0] mag;
		mag = v[CW-1] ? CW'(-v) : CW'(v);
		mag = mag >> s;
		return v[CW-1] ? -signed'(mag) : signed'(mag);
	endfunction

	// Position of the highest set bit plus one
	function automatic logic [LEN_W-1:0] bit_len(input logic [WIDE-1:0] v);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int j = 0; j < WIDE; j++) begin
			if (v[j]) n = LEN_W'(j + 1);
		end
		return n;
	endfunction

endpackage

### rtl/core/scara_inverse_kinematics_core.sv
// Top level of the SCARA inverse kinematics core: registers, pipeline and output buffer.
`timescale 1ns / 1ps
// Converts one target point (x, y, z; signed Q16.16) per clock into SCARA joint values:
// shoulder (signed Q4.16) and elbow (Q2.16) angles in radians and the lift extension -z
// (Q16.16). Words stream in at one per cycle unless both output buffer entries hold. Each
// word passes through squares, reach test and normalization, the bit-per-stage square
// root, the three parallel atan2 units, rounding and clamping and the output register.
// A two-entry output buffer keeps the input taking words while a result waits; input ready
// drops only when both entries hold. Unreachable targets give reachable = 0 with all joint
// fields zero. Link lengths and the z window are written through the configuration port;
// the user must do so only while no word is in flight, which the block does not enforce.
module scara_inverse_kinematics_core
	import sik_pkg::*;
#(
	parameter int CORDIC_STAGES = sik_pkg::CORDIC_STAGES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// target_x [31:0], target_y [63:32], target_z [95:64]
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// reachable [0], shoulder_angle [20:1], elbow_angle [38:21], lift_extension [70:39]
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_addr,
	input  logic [WORD_BITS-1:0] cfg_wdata
);

	localparam int VEC_LAT = CORDIC_STAGES + 4;
	localparam logic signed [ELBOW_EXT_W-1:0] PI_CLAMP = ELBOW_EXT_W'(PI_FIXED);

	sik_cfg_t cfg_q;
	logic en;

	logic fe_vld, sq_vld;
	sik_side_t fe_side, sq_side;
	logic [RAD_W-1:0] fe_rad;
	logic [NORM_BITS-1:0] hn;
	logic signed [WIDE-1:0] ang_yx, ang_el, ang_d;

	logic                        tail_vld_q   [VEC_LAT];
	logic                        tail_reach_q [VEC_LAT];
	logic signed [WORD_BITS-1:0] tail_lift_q  [VEC_LAT];

	logic vld_s1, reach_s1, vld_s2;
	logic signed [WORD_BITS-1:0] lift_s1;
	logic signed [ELBOW_EXT_W-1:0] elbow_s1;
	logic signed [WIDE-1:0] diff_s1, sh_full;
	logic [ELBOW_W-1:0] elbow_c;
	logic [OUT_W-1:0] data_s2;

	logic out_vld_q, skid_vld_q, out_free;
	logic [OUT_W-1:0] out_data_q, skid_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FIRST_LINK:  cfg_q.a <= cfg_wdata[LINK_W-1:0];
				REG_SECOND_LINK: cfg_q.b <= cfg_wdata[LINK_W-1:0];
				REG_Z_LOWEST:    cfg_q.z_lo <= $signed(cfg_wdata);
				REG_Z_HIGHEST:   cfg_q.z_hi <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless the output buffer is full
	assign en = ~skid_vld_q;
	assign s_tready = en;

	sik_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_tvalid),
		.in_data  (s_tdata),
		.cfg      (cfg_q),
		.out_vld  (fe_vld),
		.out_side (fe_side),
		.out_rad  (fe_rad)
	);

	sik_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (fe_vld),
		.in_side  (fe_side),
		.in_rad   (fe_rad),
		.out_vld  (sq_vld),
		.out_side (sq_side),
		.out_root (hn)
	);

	// atan2(y, x) of the target
	sik_vec #(.STAGES(CORDIC_STAGES)) u_vec_yx (
		.clk   (clk),
		.en    (en),
		.ny    (sq_side.xy.ny),
		.my    (WIDE'(sq_side.xy.uy)),
		.nx    (sq_side.xy.nx),
		.mx    (WIDE'(sq_side.xy.ux)),
		.angle (ang_yx)
	);

	// Elbow angle atan2(h, k)
	sik_vec #(.STAGES(CORDIC_STAGES)) u_vec_el (
		.clk   (clk),
		.en    (en),
		.ny    (1'b0),
		.my    (WIDE'(hn)),
		.nx    (sq_side.kneg),
		.mx    (WIDE'(sq_side.kn)),
		.angle (ang_el)
	);

	// Link offset angle atan2(h, 2a^2 + k)
	sik_vec #(.STAGES(CORDIC_STAGES)) u_vec_d (
		.clk   (clk),
		.en    (en),
		.ny    (1'b0),
		.my    (WIDE'(hn)),
		.nx    (sq_side.dneg),
		.mx    (sq_side.dm),
		.angle (ang_d)
	);

	// Reach flag and lift follow the CORDIC latency
	for (genvar t = 0; t < VEC_LAT; t++) begin : g_tail
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tail_vld_q[t] <= 1'b0;
			else if (en) tail_vld_q[t] <= (t == 0) ? sq_vld : tail_vld_q[(t == 0) ? 0 : t-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				tail_reach_q[t] <= (t == 0) ? sq_side.reach : tail_reach_q[(t == 0) ? 0 : t-1];
				tail_lift_q[t]  <= (t == 0) ? sq_side.xy.lift : tail_lift_q[(t == 0) ? 0 : t-1];
			end
		end
	end

	// Stage 1: elbow rounding, shoulder difference
	always_ff @(posedge clk) begin
		if (en) begin
			reach_s1 <= tail_reach_q[VEC_LAT-1];
			lift_s1  <= tail_lift_q[VEC_LAT-1];
			elbow_s1 <= ELBOW_EXT_W'(to_fixed(ang_el));
			diff_s1  <= ang_yx - ang_d;
		end
	end

	// Elbow clamp to [0, pi] and shoulder rounding
	always_comb begin
		sh_full = to_fixed(diff_s1);
		if (elbow_s1 < 0) elbow_c = '0;
		else if (elbow_s1 > PI_CLAMP) elbow_c = ELBOW_W'(PI_CLAMP);
		else elbow_c = elbow_s1[ELBOW_W-1:0];
	end

	// Stage 2: packed result word
	always_ff @(posedge clk) begin
		if (en) begin
			if (reach_s1) data_s2 <= {1'b0, lift_s1, elbow_c, sh_full[SHOULDER_W-1:0], 1'b1};
			else data_s2 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= tail_vld_q[VEC_LAT-1];
			vld_s2 <= vld_s1;
		end
	end

	// Output register with one-word skid buffer
	assign out_free = ~out_vld_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_s2;
			end
		end else if (vld_s2 && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) out_data_q <= skid_vld_q ? skid_data_q : data_s2;
		else if (vld_s2 && en) skid_data_q <= data_s2;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// Unreachable results carry all-zero joint fields
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_W-1:1] == '0))
		else $error("unreachable result with nonzero joint fields");

	// Skid entry only fills while the output word is stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid buffer filled without output stall");

	// Elbow stays within [0, pi]
	a_elbow_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[38:21] <= ELBOW_W'(PI_FIXED)))
		else $error("elbow angle beyond pi");

endmodule

### rtl/core/sik_front.sv
// Front pipeline: squares, reach test, normalization and the sqrt radicand.
`timescale 1ns / 1ps
module sik_front
	import sik_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [IN_W-1:0]  in_data,
	input  sik_cfg_t         cfg,
	output logic             out_vld,
	output sik_side_t        out_side,
	output logic [RAD_W-1:0] out_rad
);

	logic [WORD_BITS-1:0] x, y, z, ux, uy;
	logic signed [WORD_BITS-1:0] lift;
	logic zok;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	sik_xy_t xy_s1, xy_s2, xy_s3, xy_s4, xy_s5, xy_s6, xy_s7;
	logic zok_s1, zok_s2, zok_s3;
	logic reach_s4, reach_s5, reach_s6, reach_s7;
	logic [WIDE-1:0] sqx_s1, sqy_s1, sqa_s1, sqb_s1, ab_s1;
	logic [WIDE-1:0] s2_s2, t2_s2, c_s2, p_s2, q_s2;
	logic [WIDE-1:0] c_s3, km_s3, dm_s3;
	logic kneg_s3, dneg_s3, kneg_s4, dneg_s4, kneg_s5, dneg_s5;
	logic kneg_s6, dneg_s6, kneg_s7, dneg_s7;
	logic [WIDE-1:0] c_s4, km_s4, dm_s4;
	logic [LEN_W-1:0] len_s4;
	logic [WIDE-1:0] cw, kw, dmn, dm_s5, dm_s6, dm_s7;
	logic [LEN_W-1:0] rs, ls;
	logic [NORM_BITS-1:0] cn_s5, kn_s5, kn_s6, kn_s7;
	logic [RAD_W-1:0] cc_s6, kk_s6, rad_s7;

	// Input split, magnitudes, z window and lift
	always_comb begin
		x = in_data[WORD_BITS-1:0];
		y = in_data[2*WORD_BITS-1:WORD_BITS];
		z = in_data[3*WORD_BITS-1:2*WORD_BITS];
		ux = x[WORD_BITS-1] ? (~x + 32'd1) : x;
		uy = y[WORD_BITS-1] ? (~y + 32'd1) : y;
		zok = ($signed(z) >= cfg.z_lo) && ($signed(z) <= cfg.z_hi);
		if (z == {1'b1, {(WORD_BITS-1){1'b0}}}) lift = {1'b0, {(WORD_BITS-1){1'b1}}};
		else lift = $signed(~z + 32'd1);
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Stage 1: squares and link products
	always_ff @(posedge clk) begin
		if (en) begin
			xy_s1  <= '{nx: x[WORD_BITS-1], ny: y[WORD_BITS-1], ux: ux, uy: uy, lift: lift};
			zok_s1 <= zok;
			sqx_s1 <= WIDE'(ux) * WIDE'(ux);
			sqy_s1 <= WIDE'(uy) * WIDE'(uy);
			sqa_s1 <= WIDE'(cfg.a) * WIDE'(cfg.a);
			sqb_s1 <= WIDE'(cfg.b) * WIDE'(cfg.b);
			ab_s1  <= WIDE'(cfg.a) * WIDE'(cfg.b);
		end
	end

	// Stage 2: sums
	always_ff @(posedge clk) begin
		if (en) begin
			xy_s2  <= xy_s1;
			zok_s2 <= zok_s1;
			s2_s2  <= sqx_s1 + sqy_s1;
			t2_s2  <= sqa_s1 + sqb_s1;
			c_s2   <= {ab_s1[WIDE-2:0], 1'b0};
			p_s2   <= sqx_s1 + sqy_s1 + sqa_s1;
			q_s2   <= sqb_s1;
		end
	end

	// Stage 3: k and the second-atan x term as sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			xy_s3   <= xy_s2;
			zok_s3  <= zok_s2;
			c_s3    <= c_s2;
			kneg_s3 <= s2_s2 < t2_s2;
			km_s3   <= (s2_s2 < t2_s2) ? (t2_s2 - s2_s2) : (s2_s2 - t2_s2);
			dneg_s3 <= p_s2 < q_s2;
			dm_s3   <= (p_s2 < q_s2) ? (q_s2 - p_s2) : (p_s2 - q_s2);
		end
	end

	// Stage 4: reach test and length of 2ab
	always_ff @(posedge clk) begin
		if (en) begin
			xy_s4    <= xy_s3;
			reach_s4 <= zok_s3 && (km_s3 <= c_s3);
			len_s4   <= bit_len(c_s3);
			c_s4     <= c_s3;
			km_s4    <= km_s3;
			dm_s4    <= dm_s3;
			kneg_s4  <= kneg_s3;
			dneg_s4  <= dneg_s3;
		end
	end

	// Normalize 2ab to the CORDIC width, same shift for k and the x term
	always_comb begin
		rs = len_s4 - LEN_W'(NORM_BITS);
		ls = LEN_W'(NORM_BITS) - len_s4;
		if (len_s4 == '0) begin
			cw = '0;
			kw = '0;
			dmn = dm_s4;
		end else if (len_s4 > LEN_W'(NORM_BITS)) begin
			cw = c_s4 >> rs;
			kw = km_s4 >> rs;
			dmn = dm_s4 >> rs;
		end else begin
			cw = c_s4 << ls;
			kw = km_s4 << ls;
			dmn = dm_s4 << ls;
		end
	end

	// Stage 5: normalized terms
	always_ff @(posedge clk) begin
		if (en) begin
			xy_s5    <= xy_s4;
			reach_s5 <= reach_s4;
			kneg_s5  <= kneg_s4;
			dneg_s5  <= dneg_s4;
			cn_s5    <= cw[NORM_BITS-1:0];
			kn_s5    <= kw[NORM_BITS-1:0];
			dm_s5    <= dmn;
		end
	end

	// Stage 6: squares of the normalized terms
	always_ff @(posedge clk) begin
		if (en) begin
			xy_s6    <= xy_s5;
			reach_s6 <= reach_s5;
			kneg_s6  <= kneg_s5;
			dneg_s6  <= dneg_s5;
			kn_s6    <= kn_s5;
			dm_s6    <= dm_s5;
			cc_s6    <= RAD_W'(cn_s5) * RAD_W'(cn_s5);
			kk_s6    <= RAD_W'(kn_s5) * RAD_W'(kn_s5);
		end
	end

	// Stage 7: radicand (2ab)^2 - k^2
	always_ff @(posedge clk) begin
		if (en) begin
			xy_s7    <= xy_s6;
			reach_s7 <= reach_s6;
			kneg_s7  <= kneg_s6;
			dneg_s7  <= dneg_s6;
			kn_s7    <= kn_s6;
			dm_s7    <= dm_s6;
			rad_s7   <= cc_s6 - kk_s6;
		end
	end

	assign out_vld  = vld_s7;
	assign out_rad  = rad_s7;
	assign out_side = '{xy: xy_s7, reach: reach_s7, kneg: kneg_s7, kn: kn_s7,
		dneg: dneg_s7, dm: dm_s7};

endmodule

### rtl/core/sik_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module sik_sqrt
	import sik_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  sik_side_t            in_side,
	input  logic [RAD_W-1:0]     in_rad,
	output logic                 out_vld,
	output sik_side_t            out_side,
	output logic [NORM_BITS-1:0] out_root
);

	localparam int REM_W = NORM_BITS + 3;

	logic                 vld_s  [NORM_BITS];
	sik_side_t            side_s [NORM_BITS];
	logic [RAD_W-1:0]     rad_s  [NORM_BITS];
	logic [NORM_BITS-1:0] root_s [NORM_BITS];
	logic [REM_W-1:0]     rem_s  [NORM_BITS];

	for (genvar k = 0; k < NORM_BITS; k++) begin : g_bit
		logic                 vp;
		sik_side_t            sp;
		logic [RAD_W-1:0]     radp;
		logic [NORM_BITS-1:0] rootp;
		logic [REM_W-1:0]     remp, rem_sh, trial;

		if (k == 0) begin : g_first
			assign vp    = in_vld;
			assign sp    = in_side;
			assign radp  = in_rad;
			assign rootp = '0;
			assign remp  = '0;
		end else begin : g_next
			assign vp    = vld_s[k-1];
			assign sp    = side_s[k-1];
			assign radp  = rad_s[k-1];
			assign rootp = root_s[k-1];
			assign remp  = rem_s[k-1];
		end

		// Bring down the next two radicand bits, try root*4+1
		assign rem_sh = {remp[REM_W-3:0], radp[2*(NORM_BITS-1-k) +: 2]};
		assign trial  = {1'b0, rootp, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= sp;
				rad_s[k]  <= radp;
				if (rem_sh >= trial) begin
					rem_s[k]  <= rem_sh - trial;
					root_s[k] <= {rootp[NORM_BITS-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_sh;
					root_s[k] <= {rootp[NORM_BITS-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[NORM_BITS-1];
	assign out_side = side_s[NORM_BITS-1];
	assign out_root = root_s[NORM_BITS-1];

endmodule

### rtl/core/sik_vec.sv
// Vectoring CORDIC atan2 with operand normalization, Q60 angle out.
`timescale 1ns / 1ps
module sik_vec
	import sik_pkg::*;
#(
	parameter int STAGES = CORDIC_STAGES
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic                   ny,
	input  logic [WIDE-1:0]        my,
	input  logic                   nx,
	input  logic [WIDE-1:0]        mx,
	output logic signed [WIDE-1:0] angle
);

	logic spec_s1, spec_s2, spec_s3;
	logic signed [WIDE-1:0] sang_s1, sang_s2, sang_s3;
	logic signed [WIDE-1:0] off_s1, off_s2, off_s3;
	logic negy_s1, negy_s2;
	logic [WIDE-1:0] mx_s1, my_s1, m_s1, mx_s2, my_s2;
	logic [LEN_W-1:0] len_s2, rs, ls;
	logic [WIDE-1:0] mxn, myn;
	logic signed [CW-1:0] xs_s3, ys_s3;

	logic signed [CW-1:0]   x_s    [STAGES];
	logic signed [CW-1:0]   y_s    [STAGES];
	logic signed [WIDE-1:0] acc_s  [STAGES];
	logic                   spec_r [STAGES];
	logic signed [WIDE-1:0] sang_r [STAGES];
	logic signed [WIDE-1:0] off_r  [STAGES];
	logic signed [WIDE-1:0] ang_sout;

	// Stage 1: special cases, quadrant offset, larger magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1 <= (my == '0);
			sang_s1 <= (nx && (mx != '0)) ? PI_Q60 : '0;
			off_s1  <= nx ? (ny ? -PI_Q60 : PI_Q60) : '0;
			negy_s1 <= ny != nx;
			mx_s1   <= mx;
			my_s1   <= my;
			m_s1    <= (mx > my) ? mx : my;
		end
	end

	// Stage 2: bit length of the larger magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			spec_s2 <= spec_s1;
			sang_s2 <= sang_s1;
			off_s2  <= off_s1;
			negy_s2 <= negy_s1;
			mx_s2   <= mx_s1;
			my_s2   <= my_s1;
			len_s2  <= bit_len(m_s1);
		end
	end

	// Scale both terms to the working width
	always_comb begin
		rs = len_s2 - LEN_W'(NORM_BITS);
		ls = LEN_W'(NORM_BITS) - len_s2;
		if (len_s2 > LEN_W'(NORM_BITS)) begin
			mxn = mx_s2 >> rs;
			myn = my_s2 >> rs;
		end else begin
			mxn = mx_s2 << ls;
			myn = my_s2 << ls;
		end
	end

	// Stage 3: starting vector
	always_ff @(posedge clk) begin
		if (en) begin
			spec_s3 <= spec_s2;
			sang_s3 <= sang_s2;
			off_s3  <= off_s2;
			xs_s3   <= signed'(CW'(mxn[NORM_BITS-1:0]));
			ys_s3   <= negy_s2 ? -signed'(CW'(myn[NORM_BITS-1:0]))
				: signed'(CW'(myn[NORM_BITS-1:0]));
		end
	end

	// Rotation stages
	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam logic signed [WIDE-1:0] STEP = atan_pow2(i);
		logic signed [CW-1:0]   xp, yp, dx, dy;
		logic signed [WIDE-1:0] ap, sp_ang, op;
		logic                   sp;

		if (i == 0) begin : g_first
			assign xp = xs_s3;
			assign yp = ys_s3;
			assign ap = '0;
			assign sp = spec_s3;
			assign sp_ang = sang_s3;
			assign op = off_s3;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign ap = acc_s[i-1];
			assign sp = spec_r[i-1];
			assign sp_ang = sang_r[i-1];
			assign op = off_r[i-1];
		end

		assign dx = shr_trunc(yp, i);
		assign dy = shr_trunc(xp, i);

		always_ff @(posedge clk) begin
			if (en) begin
				spec_r[i] <= sp;
				sang_r[i] <= sp_ang;
				off_r[i]  <= op;
				if (yp > 0) begin
					x_s[i]   <= xp + dx;
					y_s[i]   <= yp - dy;
					acc_s[i] <= ap + STEP;
				end else begin
					x_s[i]   <= xp - dx;
					y_s[i]   <= yp + dy;
					acc_s[i] <= ap - STEP;
				end
			end
		end
	end

	// Final angle
	always_ff @(posedge clk) begin
		if (en) begin
			ang_sout <= spec_r[STAGES-1] ? sang_r[STAGES-1]
				: off_r[STAGES-1] + acc_s[STAGES-1];
		end
	end

	assign angle = ang_sout;

endmodule
